// ----- design/bsc_pkg.sv -----
// Shared types, constants and helpers for the barometric compensation block.
package bsc_pkg;

    localparam int NumRegs = 6;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 32;

    localparam logic [CfgIdxW-1:0] RegAc1Ac2 = 3'd0;
    localparam logic [CfgIdxW-1:0] RegAc3Ac4 = 3'd1;
    localparam logic [CfgIdxW-1:0] RegAc5Ac6 = 3'd2;
    localparam logic [CfgIdxW-1:0] RegB1B2 = 3'd3;
    localparam logic [CfgIdxW-1:0] RegMcMd = 3'd4;
    localparam logic [CfgIdxW-1:0] RegOss = 3'd5;

    localparam logic [31:0] PMax = 32'd1048575;
    localparam int DivSteps = 32;

    typedef struct packed {
        logic [15:0] raw_temp;
        logic [23:0] raw_pressure;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] temperature;
        logic [19:0] pressure;
        logic div_error;
    } t_out_item;

    typedef struct packed {
        logic [31:0] ac1_ac2;
        logic [31:0] ac3_ac4;
        logic [31:0] ac5_ac6;
        logic [31:0] b1_b2;
        logic [31:0] mc_md;
        logic [1:0] oss;
    } t_coef;

    // Front part result: an item with its temperature divide prepared.
    typedef struct packed {
        logic [23:0] raw_pressure;
        logic [31:0] x1;
        logic [31:0] num;
        logic [31:0] den;
        logic den_zero;
    } t_job;

    function automatic logic [31:0] asr(input logic [31:0] v, input int n);
        asr = 32'($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] hs(input logic [31:0] r);
        hs = {{16{r[31]}}, r[31:16]};
    endfunction

    function automatic logic [31:0] ls(input logic [31:0] r);
        ls = {{16{r[15]}}, r[15:0]};
    endfunction

endpackage

// ----- design/bsc_stream_if.sv -----
// Valid/ready channel interface used by the input and output ports.
interface bsc_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- design/bsc_front.sv -----
// Front part: takes raw readings and forms the temperature divide operands.
module bsc_front (
    input  logic i_clk,
    input  logic i_rst_n,
    input  bsc_pkg::t_coef i_coef,
    input  logic i_valid,
    output logic o_ready,
    input  bsc_pkg::t_in_item i_item,
    output logic o_valid,
    input  logic i_ready,
    output bsc_pkg::t_job o_job
);
    logic r_v1, r_v2;
    logic [31:0] r_diff, r_ac5, r_mcs, r_md;
    logic [23:0] r_rp1;
    bsc_pkg::t_job r_job;
    logic [31:0] w_x1, w_den;
    logic adv;

    assign adv = !r_v2 || i_ready;
    assign o_ready = adv;
    assign o_valid = r_v2;
    assign o_job = r_job;
    assign w_x1 = bsc_pkg::asr(r_diff * r_ac5, 15);
    assign w_den = w_x1 + r_md;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        if (adv) begin
            r_diff <= {16'd0, i_item.raw_temp} - {16'd0, i_coef.ac5_ac6[15:0]};
            r_ac5 <= {16'd0, i_coef.ac5_ac6[31:16]};
            r_mcs <= bsc_pkg::hs(i_coef.mc_md) << 11;
            r_md <= bsc_pkg::ls(i_coef.mc_md);
            r_rp1 <= i_item.raw_pressure;
            r_job.raw_pressure <= r_rp1;
            r_job.x1 <= w_x1;
            r_job.num <= r_mcs;
            r_job.den <= w_den;
            r_job.den_zero <= (w_den == 32'd0);
        end
    end
endmodule

// ----- design/bsc_fifo.sv -----
// Short queue between the front and back parts.
module bsc_fifo (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  bsc_pkg::t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output bsc_pkg::t_job o_job
);
    bsc_pkg::t_job r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic wr, rd;

    assign o_ready = r_cnt != 3'd4;
    assign o_valid = r_cnt != 3'd0;
    assign o_job = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 2'd0;
            r_rp <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (wr) r_wp <= r_wp + 2'd1;
            if (rd) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, wr} - {2'd0, rd};
        end
        if (wr) r_mem[r_wp] <= i_job;
    end
endmodule

// ----- design/bsc_back.sv -----
// Back part: pipelined divides and pressure compensation chain.
module bsc_back (
    input  logic i_clk,
    input  logic i_rst_n,
    input  bsc_pkg::t_coef i_coef,
    input  logic i_valid,
    output logic o_ready,
    input  bsc_pkg::t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output bsc_pkg::t_out_item o_item
);
    localparam int S = bsc_pkg::DivSteps;

    // Temperature divide: signed restoring divide, one quotient bit per stage.
    logic [S:0] r_tv;
    logic [31:0] r_tn [S+1];
    logic [31:0] r_td [S+1];
    logic [31:0] r_tr [S+1];
    logic [31:0] r_tq [S+1];
    logic [S:0] r_tneg, r_tz;
    logic [31:0] r_tx1 [S+1];
    logic [23:0] r_trp [S+1];

    logic adv;
    assign adv = !o_valid || i_ready;
    assign o_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_tv <= '0;
        else if (adv) r_tv <= {r_tv[S-1:0], i_valid};
        if (adv) begin
            r_tn[0] <= i_job.num[31] ? -i_job.num : i_job.num;
            r_td[0] <= i_job.den[31] ? -i_job.den : i_job.den;
            r_tr[0] <= '0;
            r_tq[0] <= '0;
            r_tneg[0] <= i_job.num[31] ^ i_job.den[31];
            r_tz[0] <= i_job.den_zero;
            r_tx1[0] <= i_job.x1;
            r_trp[0] <= i_job.raw_pressure;
        end
    end

    for (genvar k = 0; k < S; k++) begin : g_tdiv
        logic [32:0] w_rem, w_sub;
        assign w_rem = {r_tr[k], r_tn[k][31-k]};
        assign w_sub = w_rem - {1'b0, r_td[k]};
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_tr[k+1] <= w_sub[32] ? w_rem[31:0] : w_sub[31:0];
                r_tq[k+1] <= r_tq[k] | (32'(!w_sub[32]) << (31 - k));
                r_tn[k+1] <= r_tn[k];
                r_td[k+1] <= r_td[k];
                r_tneg[k+1] <= r_tneg[k];
                r_tz[k+1] <= r_tz[k];
                r_tx1[k+1] <= r_tx1[k];
                r_trp[k+1] <= r_trp[k];
            end
        end
    end

    // Stages after the temperature divide.
    logic r_a_v, r_b_v, r_c_v, r_d_v, r_e_v;
    logic r_a_z, r_b_z, r_c_z, r_d_z;
    logic [31:0] r_b6;
    logic [23:0] r_a_rp, r_b_rp, r_c_rp;
    logic [15:0] r_a_t, r_b_t, r_c_t, r_d_t;
    logic [31:0] w_x2, w_b5, w_t32;
    logic [15:0] w_tsat;

    assign w_x2 = r_tneg[S] ? -r_tq[S] : r_tq[S];
    assign w_b5 = r_tx1[S] + w_x2;
    assign w_t32 = bsc_pkg::asr(w_b5 + 32'd8, 4);
    assign w_tsat = ($signed(w_t32) > 32'sd32767) ? 16'h7fff :
                    ($signed(w_t32) < -32'sd32768) ? 16'h8000 : w_t32[15:0];

    logic [31:0] r_sqp, r_m1, r_m2, r_m3;
    logic [31:0] r_up;
    logic [31:0] w_sq, w_b3, w_x3b, w_b4;
    logic [31:0] r_b3, r_x3b;
    logic [31:0] w_b4full;
    logic [31:0] r_b4, r_b7;

    assign w_sq = bsc_pkg::asr(r_sqp, 12);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else if (adv) begin
            r_a_v <= r_tv[S];
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
        end
        if (adv) begin
            r_a_z <= r_tz[S];
            r_a_t <= w_tsat;
            r_a_rp <= r_trp[S];
            r_b6 <= w_b5 - 32'd4000;
            r_sqp <= (w_b5 - 32'd4000) * (w_b5 - 32'd4000);
            r_b_z <= r_a_z;
            r_b_t <= r_a_t;
            r_b_rp <= r_a_rp;
            r_m1 <= bsc_pkg::asr(bsc_pkg::ls(i_coef.b1_b2) * w_sq, 11);
            r_m2 <= bsc_pkg::asr(bsc_pkg::ls(i_coef.ac1_ac2) * r_b6, 11);
            r_m3 <= bsc_pkg::asr(bsc_pkg::hs(i_coef.ac3_ac4) * r_b6, 13)
                  + bsc_pkg::asr(bsc_pkg::hs(i_coef.b1_b2) * w_sq, 16);
            r_c_z <= r_b_z;
            r_c_t <= r_b_t;
            r_c_rp <= r_b_rp;
            r_b3 <= w_b3;
            r_x3b <= w_x3b;
            r_d_z <= r_c_z || (w_b4 == 32'd0);
            r_d_t <= r_c_t;
            r_b4 <= w_b4;
            r_b7 <= ({8'd0, r_c_rp} >> (4'd8 - {2'd0, i_coef.oss}) ) - r_b3;
        end
    end

    assign w_b3 = bsc_pkg::asr((((bsc_pkg::hs(i_coef.ac1_ac2) << 2) + r_m1 + r_m2)
                  << i_coef.oss) + 32'd2, 2);
    assign w_x3b = bsc_pkg::asr(r_m3 + 32'd2, 2);
    assign w_b4full = {16'd0, i_coef.ac3_ac4[15:0]} * (r_x3b + 32'd32768);
    assign w_b4 = w_b4full >> 15;

    // B7 multiply, then unsigned divide pipeline.
    logic r_f_v, r_f_z;
    logic [15:0] r_f_t;
    logic [31:0] r_b7m, r_f_b4;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_f_v <= 1'b0;
        else if (adv) r_f_v <= r_d_v;
        if (adv) begin
            r_f_z <= r_d_z;
            r_f_t <= r_d_t;
            r_f_b4 <= r_b4;
            r_b7m <= r_b7 * (32'd50000 >> i_coef.oss);
        end
    end

    logic [S:0] r_pv;
    logic [31:0] r_pn [S+1];
    logic [31:0] r_pd [S+1];
    logic [31:0] r_pr [S+1];
    logic [31:0] r_pq [S+1];
    logic [S:0] r_pz, r_ph;
    logic [15:0] r_pt [S+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pv <= '0;
        else if (adv) r_pv <= {r_pv[S-1:0], r_f_v};
        if (adv) begin
            r_pn[0] <= r_b7m[31] ? r_b7m : (r_b7m << 1);
            r_ph[0] <= r_b7m[31];
            r_pd[0] <= r_f_b4;
            r_pr[0] <= '0;
            r_pq[0] <= '0;
            r_pz[0] <= r_f_z;
            r_pt[0] <= r_f_t;
        end
    end

    for (genvar k = 0; k < S; k++) begin : g_pdiv
        logic [32:0] w_rem, w_sub;
        assign w_rem = {r_pr[k], r_pn[k][31-k]};
        assign w_sub = w_rem - {1'b0, r_pd[k]};
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_pr[k+1] <= w_sub[32] ? w_rem[31:0] : w_sub[31:0];
                r_pq[k+1] <= r_pq[k] | (32'(!w_sub[32]) << (31 - k));
                r_pn[k+1] <= r_pn[k];
                r_pd[k+1] <= r_pd[k];
                r_pz[k+1] <= r_pz[k];
                r_ph[k+1] <= r_ph[k];
                r_pt[k+1] <= r_pt[k];
            end
        end
    end

    // Final correction polynomial.
    logic [31:0] w_p, w_p8;
    logic [31:0] r_g_p, r_g_sq, r_g_x2;
    logic r_g_z;
    logic [15:0] r_g_t;
    logic [31:0] r_h_p, r_h_x1, r_h_x2;
    logic r_h_z;
    logic [15:0] r_h_t;
    logic [31:0] w_pf;
    bsc_pkg::t_out_item r_out;

    assign w_p = r_ph[S] ? (r_pq[S] << 1) : r_pq[S];
    assign w_p8 = bsc_pkg::asr(w_p, 8);
    assign w_pf = r_h_p + bsc_pkg::asr(r_h_x1 + r_h_x2 + 32'd3791, 4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (adv) begin
            r_e_v <= r_pv[S];
        end
        if (adv) begin
            r_g_p <= w_p;
            r_g_sq <= w_p8 * w_p8;
            r_g_x2 <= bsc_pkg::asr(32'd0 - 32'd7357 * w_p, 16);
            r_g_z <= r_pz[S];
            r_g_t <= r_pt[S];
            r_h_p <= r_g_p;
            r_h_x1 <= bsc_pkg::asr(r_g_sq * 32'd3038, 16);
            r_h_x2 <= r_g_x2;
            r_h_z <= r_g_z;
            r_h_t <= r_g_t;
            r_out.div_error <= r_h_z;
            r_out.temperature <= r_h_z ? 16'sd0 : $signed(r_h_t);
            r_out.pressure <= (r_h_z || w_pf[31]) ? 20'd0 :
                              (w_pf > bsc_pkg::PMax) ? 20'hfffff : w_pf[19:0];
        end
    end

    logic r_g_v, r_h_v;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
            r_h_v <= 1'b0;
        end else if (adv) begin
            r_g_v <= r_e_v;
            r_h_v <= r_g_v;
        end
    end

    assign o_valid = r_h_v;
    assign o_item = r_out;
endmodule

// ----- design/baro_sensor_compensation.sv -----
// Top level of the barometric sensor compensation block.
// One reading (raw temperature and raw pressure) is taken per clock and one
// result leaves per clock when nothing stalls; the two divider pipelines,
// one quotient bit per stage, make up most of the pipeline depth. Both sides
// may stall independently; a four-entry queue separates the input stage
// from the compute pipeline.
// Calibration registers must only be written while no reading is in flight.
module baro_sensor_compensation (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [bsc_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [bsc_pkg::CfgDataW-1:0] i_cfg_data,
    bsc_stream_if.sink i_in,
    bsc_stream_if.source o_out
);
    bsc_pkg::t_coef r_coef;
    bsc_pkg::t_job w_fj, w_qj;
    logic w_fv, w_fr, w_qv, w_qr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bsc_pkg::RegAc1Ac2: r_coef.ac1_ac2 <= i_cfg_data;
                bsc_pkg::RegAc3Ac4: r_coef.ac3_ac4 <= i_cfg_data;
                bsc_pkg::RegAc5Ac6: r_coef.ac5_ac6 <= i_cfg_data;
                bsc_pkg::RegB1B2: r_coef.b1_b2 <= i_cfg_data;
                bsc_pkg::RegMcMd: r_coef.mc_md <= i_cfg_data;
                bsc_pkg::RegOss: r_coef.oss <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    bsc_front u_front (
        .i_clk, .i_rst_n, .i_coef(r_coef),
        .i_valid(i_in.valid), .o_ready(i_in.ready), .i_item(i_in.data),
        .o_valid(w_fv), .i_ready(w_fr), .o_job(w_fj)
    );

    bsc_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_valid(w_fv), .o_ready(w_fr), .i_job(w_fj),
        .o_valid(w_qv), .i_ready(w_qr), .o_job(w_qj)
    );

    bsc_back u_back (
        .i_clk, .i_rst_n, .i_coef(r_coef),
        .i_valid(w_qv), .o_ready(w_qr), .i_job(w_qj),
        .o_valid(o_out.valid), .i_ready(o_out.ready), .o_item(o_out.data)
    );
endmodule
